[hw/rtl/double_ended_queue_unit_assert.svh]
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

[hw/rtl/deq_pkg.sv]
package deq_pkg;

    typedef enum logic [1:0] {
        ACT_INS_FRONT = 2'd0,
        ACT_INS_REAR  = 2'd1,
        ACT_DEL_FRONT = 2'd2,
        ACT_DEL_REAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    localparam logic [1:0] MODE_INPUT_RESTRICTED  = 2'd1;
    localparam logic [1:0] MODE_OUTPUT_RESTRICTED = 2'd2;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_OUT_W = 5;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } deq_cmd_t;

    typedef struct packed {
        logic out_room;
    } deq_stat_t;

endpackage

[hw/rtl/deq_ctrl.sv]
module deq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_room)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/deq_datapath.sv]
`include "double_ended_queue_unit_assert.svh"

module deq_datapath
#(
    parameter int DEPTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_wr_data,
    input  deq_pkg::action_t                     action,
    input  logic signed [deq_pkg::VALUE_W-1:0]   value,
    input  deq_pkg::deq_cmd_t                    cmd,
    output deq_pkg::deq_stat_t                   stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [deq_pkg::VALUE_W-1:0]   removed_value,
    output deq_pkg::status_t                     status,
    output logic [deq_pkg::COUNT_OUT_W-1:0]      count_after
);
    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    logic [1:0]                mode_reg;
    action_t                   act_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic [IW-1:0]             front_reg;
    logic [IW-1:0]             front_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic signed [VALUE_W-1:0] rd_data_reg;
    status_t                   res_status_reg;
    status_t                   status_next;
    logic                      del_ok_reg;
    logic                      del_ok;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_removed_reg;
    status_t                   out_status_reg;
    logic [COUNT_OUT_W-1:0]    out_count_reg;

    logic          refused;
    logic          is_empty;
    logic          is_full;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] mem_addr;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [SW-1:0] rear_sum;
    logic [SW-1:0] last_sum;
    logic [IW-1:0] rear_slot;
    logic [IW-1:0] last_slot;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    // ring pointer arithmetic, each index wrapped with one compare
    always_comb
    begin
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IW'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IW'(1);
        rear_sum  = SW'(front_reg) + SW'(count_reg);
        last_sum  = rear_sum - SW'(1);
        rear_slot = (rear_sum >= DEPTH_S) ? IW'(rear_sum - DEPTH_S) : IW'(rear_sum);
        last_slot = (last_sum >= DEPTH_S) ? IW'(last_sum - DEPTH_S) : IW'(last_sum);
    end

    always_comb
    begin
        refused = (mode_reg == MODE_INPUT_RESTRICTED && act_reg == ACT_INS_FRONT) ||
                  (mode_reg == MODE_OUTPUT_RESTRICTED && act_reg == ACT_DEL_REAR);
        is_empty    = (count_reg == '0);
        is_full     = (count_reg == DEPTH_C);
        front_next  = front_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = front_reg;
        status_next = ST_OK;
        del_ok      = 1'b0;
        if (refused)
        begin
            status_next = ST_REFUSED;
        end
        else
        begin
            case (act_reg)
                ACT_INS_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        mem_addr   = front_dec;
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_INS_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_addr   = rear_slot;
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_DEL_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_addr   = front_reg;
                        mem_re     = 1'b1;
                        del_ok     = 1'b1;
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                ACT_DEL_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_addr   = last_slot;
                        mem_re     = 1'b1;
                        del_ok     = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[mem_addr] <= val_reg;
        end
        if (cmd.exec && mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_wide = (CW + COUNT_OUT_W)'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= action;
            val_reg <= value;
        end
        if (cmd.exec)
        begin
            res_status_reg <= status_next;
            del_ok_reg     <= del_ok;
        end
        if (cmd.load_out)
        begin
            out_removed_reg <= del_ok_reg ? rd_data_reg : '0;
            out_status_reg  <= res_status_reg;
            out_count_reg   <= count_wide[COUNT_OUT_W-1:0];
        end
    end

    assign stat.out_room = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign removed_value = out_removed_reg;
    assign status        = out_status_reg;
    assign count_after   = out_count_reg;

    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `DEQ_ASSERT_NEXT(a_insert_grows, cmd.exec && mem_we, count_reg == $past(count_reg) + CW'(1))
    `DEQ_ASSERT_NOW(a_load_has_room, cmd.load_out, !out_valid_reg || m_tready)

endmodule

[hw/rtl/double_ended_queue_unit.sv]
// Double-ended queue of signed 32-bit values in a ring buffer of DEPTH entries. Each input
// beat carries one action (insert front, insert rear, delete front, delete rear) and yields
// exactly one output beat with the removed value, a status code and the count after the
// action. An item goes through accept, a ring pointer update with at most one access to the
// entry memory, and a load of the output register once the registered read data is back and
// there is room; the output register lets the next beat be accepted while a result waits. The
// user must write the mode register (cfg_wr_en/cfg_wr_data) only while idle; it is not checked.
module double_ended_queue_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[1:0], value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // removed_value[31:0], status[33:32], count_after[38:34], pad
);
    import deq_pkg::*;

    deq_cmd_t                  cmd;
    deq_stat_t                 stat;
    logic signed [VALUE_W-1:0] removed_value;
    status_t                   status;
    logic [COUNT_OUT_W-1:0]    count_after;

    deq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .action        (action_t'(s_tdata[1:0])),
        .value         (s_tdata[33:2]),
        .cmd           (cmd),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .removed_value (removed_value),
        .status        (status),
        .count_after   (count_after)
    );

    assign m_tdata = {1'b0, count_after, status, removed_value};

endmodule
